### rtl/core/kmc_pkg.sv
// shared types and constants of the k-mer counting hash table
package kmc_pkg;
   localparam int PREFIX_BITS_DEF = 4;
   localparam int KEY_BITS_DEF = 50;
   localparam int SLOTS_PER_TABLE_DEF = 1024;
   localparam int MAX_PROBE_DEF = 16;
   localparam int KEY_POS = 14;
   localparam logic [7:0] CNT_MAX = 8'hff;
   localparam logic [5:0] HIGH_MAX = 6'h3f;
   localparam logic [14:0] TOTAL_MAX = 15'h7fff;
   localparam int ENTRY_W = 64;

   typedef enum logic [1:0] {
      ST_NEW = 2'd0, ST_EXIST = 2'd1, ST_NOT_FOUND = 2'd2, ST_FULL = 2'd3
   } status_type;

   typedef enum logic {CMD_INSERT = 1'b0, CMD_LOOKUP = 1'b1} cmd_type;

   typedef enum logic {REG_KMER_LEN = 1'b0, REG_PREFIX_BITS = 1'b1} reg_type;

   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_MAP, S_READ, S_CHECK, S_OUT
   } state_type;

   localparam logic [5:0] KMER_LEN_RST = 6'd31;
   localparam logic [2:0] PREFIX_RST = 3'd4;
endpackage

### rtl/core/kmc_if.sv
// valid/ready channel interfaces for request, response and register writes
interface kmc_req_if;
   logic valid;
   logic ready;
   logic cmd;
   logic [62:0] kmer_high;
   logic [62:0] kmer_low;
   logic is_high;
   modport source(output valid, cmd, kmer_high, kmer_low, is_high, input ready);
   modport sink(input valid, cmd, kmer_high, kmer_low, is_high, output ready);
endinterface

interface kmc_rsp_if;
   logic valid;
   logic ready;
   logic [1:0] status;
   logic [7:0] count;
   logic [5:0] high_count;
   logic [14:0] total_entries;
   modport source(output valid, status, count, high_count, total_entries, input ready);
   modport sink(input valid, status, count, high_count, total_entries, output ready);
endinterface

interface kmc_csr_if;
   logic valid;
   logic ready;
   logic [0:0] index;
   logic [7:0] data;
   modport source(output valid, index, data, input ready);
   modport sink(input valid, index, data, output ready);
endinterface

### rtl/core/kmer_count_hash_table.sv
// top level: k-mer counting hash table with linear probing in one ram
// A request is taken in idle and then passes through map, then read and check for each
// slot probed, then out, where its response turns valid. The next request can be taken
// the cycle after the response is taken, so one request is handled at a time. After reset
// a clearing pass writes zero to every slot, one per cycle, during which no request is
// taken; register writes are always taken. Results sit in an output register until taken.
module kmer_count_hash_table #(
   parameter int PREFIX_BITS = kmc_pkg::PREFIX_BITS_DEF,
   parameter int KEY_BITS = kmc_pkg::KEY_BITS_DEF,
   parameter int SLOTS_PER_TABLE = kmc_pkg::SLOTS_PER_TABLE_DEF,
   parameter int MAX_PROBE = kmc_pkg::MAX_PROBE_DEF
) (
   input logic clock,
   input logic reset,
   kmc_req_if.sink req,
   kmc_rsp_if.source rsp,
   kmc_csr_if.sink csr
);
   import kmc_pkg::*;
   localparam int DEPTH = SLOTS_PER_TABLE << PREFIX_BITS;
   localparam int AW = $clog2(DEPTH);
   localparam int SW = $clog2(SLOTS_PER_TABLE);
   localparam int PW = $clog2(MAX_PROBE + 1);

   state_type state_ff, state_in;
   logic [5:0] klen_ff;
   logic [2:0] pbits_ff;
   logic cmd_ff, hq_ff;
   logic [62:0] kh_ff, kl_ff;
   logic [KEY_BITS-1:0] key_ff, key_w;
   logic [PREFIX_BITS:0] sub_w;
   logic [AW-1:0] base_ff, base_in;
   logic [SW-1:0] slot_ff, slot_in;
   logic [PW-1:0] probe_ff, probe_in;
   logic [AW:0] clr_ff, clr_in;
   logic [14:0] total_ff, total_in;
   logic [1:0] st_ff, st_in;
   logic [7:0] cnt_ff, cnt_in;
   logic [5:0] hi_ff, hi_in;
   logic vld_ff, vld_in;
   logic wr_en;
   logic [AW-1:0] addr;
   logic [ENTRY_W-1:0] wdata, rdata;
   logic [7:0] ec;
   logic [5:0] eh;

   kmc_map #(.PREFIX_BITS(PREFIX_BITS), .KEY_BITS(KEY_BITS)) u_map (
      .kmer_len(klen_ff), .prefix_bits(pbits_ff), .kmer_high(kh_ff), .kmer_low(kl_ff),
      .key(key_w), .sub(sub_w));

   kmc_ram #(.WIDTH(ENTRY_W), .DEPTH(DEPTH)) u_ram (
      .clock(clock), .wr_en(wr_en), .addr(addr), .wr_data(wdata), .rd_data(rdata));

   assign csr.ready = 1'b1;
   assign req.ready = (state_ff == S_IDLE) && !vld_ff;
   assign rsp.valid = vld_ff;
   assign rsp.status = st_ff;
   assign rsp.count = cnt_ff;
   assign rsp.high_count = hi_ff;
   assign rsp.total_entries = total_ff;
   assign ec = rdata[7:0];
   assign eh = rdata[13:8];

   always_comb begin
      state_in = state_ff; base_in = base_ff; slot_in = slot_ff; probe_in = probe_ff;
      clr_in = clr_ff; total_in = total_ff; st_in = st_ff; cnt_in = cnt_ff; hi_in = hi_ff;
      vld_in = vld_ff && !rsp.ready;
      wr_en = 1'b0; wdata = '0;
      addr = base_ff | AW'(slot_ff);
      case (state_ff)
         S_CLEAR: begin
            addr = clr_ff[AW-1:0]; wr_en = 1'b1;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == (AW+1)'(DEPTH - 1)) state_in = S_IDLE;
         end
         S_IDLE: if (req.valid && req.ready) state_in = S_MAP;
         S_MAP: begin
            base_in = AW'(sub_w) << SW;
            slot_in = key_w[SW-1:0];
            probe_in = '0;
            state_in = S_READ;
         end
         S_READ: state_in = S_CHECK;
         S_CHECK: begin
            state_in = S_OUT;
            if (rdata == '0) begin
               if (cmd_ff == CMD_LOOKUP) begin
                  st_in = ST_NOT_FOUND; cnt_in = '0; hi_in = '0;
               end else begin
                  st_in = ST_NEW; cnt_in = 8'd1; hi_in = {5'd0, hq_ff};
                  wr_en = 1'b1;
                  wdata = ENTRY_W'({key_ff, 5'd0, hq_ff, 8'd1});
                  if (total_ff != TOTAL_MAX) total_in = total_ff + 1'b1;
               end
            end else if (rdata[ENTRY_W-1:KEY_POS] == (ENTRY_W-KEY_POS)'(key_ff)) begin
               st_in = ST_EXIST; cnt_in = ec; hi_in = eh;
               if (cmd_ff == CMD_INSERT) begin
                  if (ec != CNT_MAX) cnt_in = ec + 1'b1;
                  if (hq_ff && eh != HIGH_MAX) hi_in = eh + 1'b1;
                  wr_en = 1'b1;
                  wdata = ENTRY_W'({key_ff, hi_in, cnt_in});
               end
            end else if (probe_ff == PW'(MAX_PROBE - 1)) begin
               st_in = (cmd_ff == CMD_LOOKUP) ? ST_NOT_FOUND : ST_FULL;
               cnt_in = '0; hi_in = '0;
            end else begin
               slot_in = slot_ff + 1'b1; probe_in = probe_ff + 1'b1;
               state_in = S_READ;
            end
         end
         S_OUT: begin
            if (!vld_ff) begin
               vld_in = 1'b1; state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR; clr_ff <= '0; total_ff <= '0; vld_ff <= 1'b0;
         klen_ff <= KMER_LEN_RST; pbits_ff <= PREFIX_RST;
      end else begin
         state_ff <= state_in; clr_ff <= clr_in; total_ff <= total_in; vld_ff <= vld_in;
         if (csr.valid && csr.ready) begin
            case (reg_type'(csr.index))
               REG_KMER_LEN: klen_ff <= csr.data[5:0];
               REG_PREFIX_BITS: pbits_ff <= csr.data[2:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      base_ff <= base_in; slot_ff <= slot_in; probe_ff <= probe_in;
      st_ff <= st_in; cnt_ff <= cnt_in; hi_ff <= hi_in;
      if (state_ff == S_MAP) key_ff <= key_w;
      if (req.valid && req.ready) begin
         cmd_ff <= req.cmd; hq_ff <= req.is_high; kh_ff <= req.kmer_high; kl_ff <= req.kmer_low;
      end
   end

   a_no_req_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> !req.ready) else $error("request taken during clear");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (vld_ff && !rsp.ready) |=> (vld_ff && $stable(st_ff))) else $error("response lost");
   a_total_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_CLEAR && state_ff != S_CHECK) |=> $stable(total_ff))
      else $error("entry count moved outside check");
endmodule

### rtl/core/kmc_ram.sv
// generic single-port synchronous ram with registered read
module kmc_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem[addr] <= wr_data;
      rd_data_ff <= mem[addr];
   end
   assign rd_data = rd_data_ff;
endmodule

### rtl/core/kmc_map.sv
// k-mer packing into sub-table index and truncated key
module kmc_map #(
   parameter int PREFIX_BITS = kmc_pkg::PREFIX_BITS_DEF,
   parameter int KEY_BITS = kmc_pkg::KEY_BITS_DEF
) (
   input  logic [5:0]             kmer_len,
   input  logic [2:0]             prefix_bits,
   input  logic [62:0]            kmer_high,
   input  logic [62:0]            kmer_low,
   output logic [KEY_BITS-1:0]    key,
   output logic [PREFIX_BITS:0]   sub
);
   logic [63:0] mk, xh, xl, z, kfull, sfull, tmask;
   logic [7:0] k2, p, t, sh, tl;

   always_comb begin
      mk = (kmer_len == 6'd0) ? 64'd0 : (64'hffff_ffff_ffff_ffff >> (7'd64 - {1'b0, kmer_len}));
      xh = {1'b0, kmer_high} & mk;
      xl = {1'b0, kmer_low} & mk;
      k2 = {1'b0, kmer_len, 1'b0};
      p = {5'd0, prefix_bits};
      if (k2 > 8'(KEY_BITS) && (k2 - 8'(KEY_BITS)) > p) p = k2 - 8'(KEY_BITS);
      if (p > 8'(PREFIX_BITS)) p = 8'(PREFIX_BITS);
      z = '0; t = '0; sh = '0; tl = '0; tmask = '0;
      if (kmer_len <= 6'd32) begin
         if (p > k2) p = k2;
         t = k2 - p;
         z = (kmer_len == 6'd32) ? xl : ((xh << kmer_len) | xl);
         if (kmer_len == 6'd32) z = (xh << 32) | xl;
         tmask = (t >= 8'd64) ? '1 : ((64'd1 << t[5:0]) - 64'd1);
         kfull = z & tmask;
         sfull = (t >= 8'd64) ? 64'd0 : (z >> t[5:0]);
      end else begin
         t = {2'd0, kmer_len} - p;
         tl = t + {2'd0, kmer_len};
         if (tl < 8'(KEY_BITS)) sh = {2'd0, kmer_len};
         else sh = (8'(KEY_BITS) > t) ? 8'(KEY_BITS) - t : 8'd0;
         tmask = (64'd1 << t[5:0]) - 64'd1;
         kfull = (sh >= 8'd64) ? xl : (((xh & tmask) << sh[5:0]) ^ xl);
         sfull = xh >> t[5:0];
      end
      key = kfull[KEY_BITS-1:0];
      sub = sfull[PREFIX_BITS:0] & (PREFIX_BITS+1)'((64'd1 << PREFIX_BITS) - 64'd1);
   end
endmodule

### tb/kmer_count_hash_table_tb.sv
// self-checking testbench of the k-mer counting hash table with a scoreboard class
module kmer_count_hash_table_tb;
   import kmc_pkg::*;

   typedef struct packed {
      status_type st;
      logic [7:0] cnt;
      logic [5:0] hc;
      logic [14:0] tot;
   } kmer_result_type;

   typedef enum int {MIX_RANDOM, MIX_CLUSTER, MIX_HAMMER} mix_type;

   localparam int WATCHDOG_LIMIT = 60000;
   localparam int SETTLE_CYCLES = 48;

   class kmer_tally;
      logic [63:0] slots [int];
      logic [14:0] n_keys;
      logic [5:0] klen;
      logic [2:0] pfx;
      kmer_result_type pending [$];
      int errors;
      int checked;

      function new();
         n_keys = '0;
         klen = KMER_LEN_RST;
         pfx = PREFIX_RST;
         errors = 0;
         checked = 0;
      endfunction

      function logic [63:0] ones(int n);
         return n >= 64 ? '1 : (64'd1 << n) - 64'd1;
      endfunction

      function void write_reg(reg_type idx, logic [7:0] d);
         if (idx == REG_KMER_LEN) klen = d[5:0];
         else pfx = d[2:0];
      endfunction

      function void note(cmd_type cmd, logic [62:0] kh, logic [62:0] kl, logic hi);
         int k, p, t, sh, i, base, home, idx;
         logic [63:0] xh, xl, z, key, sub, e;
         kmer_result_type o;
         k = klen;
         p = pfx;
         xh = {1'b0, kh} & ones(k);
         xl = {1'b0, kl} & ones(k);
         if (2 * k > KEY_BITS_DEF && 2 * k - KEY_BITS_DEF > p) p = 2 * k - KEY_BITS_DEF;
         if (p > PREFIX_BITS_DEF) p = PREFIX_BITS_DEF;
         if (k <= 32) begin
            if (p > 2 * k) p = 2 * k;
            t = 2 * k - p;
            z = (xh << k) | xl;
            key = z & ones(t);
            sub = t >= 64 ? 64'd0 : z >> t;
         end else begin
            t = k - p;
            if (t + k < KEY_BITS_DEF) sh = k;
            else sh = KEY_BITS_DEF > t ? KEY_BITS_DEF - t : 0;
            key = ((xh & ones(t)) << sh) ^ xl;
            sub = xh >> t;
         end
         key &= ones(KEY_BITS_DEF);
         sub &= ones(PREFIX_BITS_DEF);
         base = int'(sub) * SLOTS_PER_TABLE_DEF;
         home = int'(key % SLOTS_PER_TABLE_DEF);
         o.st = cmd == CMD_LOOKUP ? ST_NOT_FOUND : ST_FULL;
         o.cnt = '0;
         o.hc = '0;
         for (i = 0; i < MAX_PROBE_DEF; i++) begin
            idx = base + (home + i) % SLOTS_PER_TABLE_DEF;
            e = slots.exists(idx) ? slots[idx] : 64'd0;
            if (e == 64'd0) begin
               if (cmd == CMD_INSERT) begin
                  o.cnt = 8'd1;
                  o.hc = {5'd0, hi};
                  slots[idx] = (key << KEY_POS) | (64'(o.hc) << 8) | 64'(o.cnt);
                  if (n_keys != TOTAL_MAX) n_keys++;
                  o.st = ST_NEW;
               end
               break;
            end
            if ((e >> KEY_POS) == key) begin
               o.cnt = e[7:0];
               o.hc = e[13:8];
               if (cmd == CMD_INSERT) begin
                  if (o.cnt != CNT_MAX) o.cnt++;
                  if (hi && o.hc != HIGH_MAX) o.hc++;
                  slots[idx] = (key << KEY_POS) | (64'(o.hc) << 8) | 64'(o.cnt);
               end
               o.st = ST_EXIST;
               break;
            end
         end
         o.tot = n_keys;
         pending.push_back(o);
      endfunction

      function void check(kmer_result_type got);
         kmer_result_type want;
         checked++;
         if (pending.size() == 0) begin
            $display("%0t: unexpected word status=%0d count=%0d", $time, got.st, got.cnt);
            errors++;
            return;
         end
         want = pending.pop_front();
         if (got.st != want.st) begin
            $display("%0t: status expected %0d actual %0d", $time, want.st, got.st);
            errors++;
         end
         if (got.cnt != want.cnt) begin
            $display("%0t: count expected %0d actual %0d", $time, want.cnt, got.cnt);
            errors++;
         end
         if (got.hc != want.hc) begin
            $display("%0t: high_count expected %0d actual %0d", $time, want.hc, got.hc);
            errors++;
         end
         if (got.tot != want.tot) begin
            $display("%0t: total_entries expected %0d actual %0d", $time, want.tot, got.tot);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic quiet = 1'b0;
   int stall_left = 0;
   int idle_cycles = 0;
   int sent = 0;
   kmer_tally tally = new();

   kmc_req_if req_if();
   kmc_rsp_if rsp_if();
   kmc_csr_if csr_if();

   kmer_count_hash_table DUT (
      .clock(clock),
      .reset(reset),
      .req(req_if.sink),
      .rsp(rsp_if.source),
      .csr(csr_if.sink)
   );

   always #1 clock = ~clock;

   initial begin
      req_if.valid = 1'b0;
      req_if.cmd = CMD_INSERT;
      req_if.kmer_high = '0;
      req_if.kmer_low = '0;
      req_if.is_high = 1'b0;
      rsp_if.ready = 1'b0;
      csr_if.valid = 1'b0;
      csr_if.index = REG_KMER_LEN;
      csr_if.data = '0;
   end

   // response side stalls in bursts while not quiet
   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_if.ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
         rsp_if.ready <= 1'b0;
         stall_left <= $urandom_range(0, 15);
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready)
         tally.check({status_type'(rsp_if.status), rsp_if.count, rsp_if.high_count,
                      rsp_if.total_entries});
   end

   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (csr_if.valid && csr_if.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("kmer_count_hash_table verification failed");
         $finish;
      end
   end

   task automatic write_reg(reg_type idx, logic [7:0] d);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data <= d;
      do @(posedge clock); while (!csr_if.ready);
      tally.write_reg(idx, d);
   endtask

   task automatic send(cmd_type cmd, logic [62:0] kh, logic [62:0] kl, logic hi);
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.cmd <= cmd;
      req_if.kmer_high <= kh;
      req_if.kmer_low <= kl;
      req_if.is_high <= hi;
      do @(posedge clock); while (!req_if.ready);
      tally.note(cmd, kh, kl, hi);
      sent++;
   endtask

   function automatic logic [62:0] rand_word();
      return 63'({$urandom, $urandom});
   endfunction

   task automatic drain();
      req_if.valid <= 1'b0;
      while (tally.pending.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic send_edges();
      send(CMD_INSERT, '0, '0, 1'b1);
      send(CMD_INSERT, '1, '1, 1'b1);
      send(CMD_LOOKUP, '1, '1, 1'b0);
      send(CMD_LOOKUP, '0, '1, 1'b0);
   endtask

   task automatic run_phase(logic [7:0] kdata, logic [7:0] pdata, mix_type mix, int n,
                            bit edges);
      logic [62:0] pool_h [$];
      logic [62:0] pool_l [$];
      logic [62:0] kh, kl;
      logic [62:0] hot_h, hot_l;
      int j, pick;
      drain();
      write_reg(REG_KMER_LEN, kdata);
      write_reg(REG_PREFIX_BITS, pdata);
      csr_if.valid <= 1'b0;
      if (edges) send_edges();
      hot_h = rand_word();
      hot_l = rand_word();
      for (j = 0; j < n; j++) begin
         case (mix)
            MIX_CLUSTER: begin
               // same sub-table and home slot near the top, wrapping around
               kh = 63'(9) << 27;
               kl = (63'(j % 22 + 1) << 10) | 63'd1020;
               send(j < 22 || j % 3 == 0 ? CMD_INSERT : CMD_LOOKUP, kh, kl, j[0]);
            end
            MIX_HAMMER: begin
               send(j % 10 == 9 ? CMD_LOOKUP : CMD_INSERT, hot_h, hot_l,
                    1'($urandom_range(0, 1)));
            end
            default: begin
               if (pool_h.size() > 0 && $urandom_range(0, 9) < 6) begin
                  pick = $urandom_range(0, pool_h.size() - 1);
                  kh = pool_h[pick];
                  kl = pool_l[pick];
               end else begin
                  kh = rand_word();
                  kl = rand_word();
                  if (pool_h.size() < 48) begin
                     pool_h.push_back(kh);
                     pool_l.push_back(kl);
                  end
               end
               send(cmd_type'($urandom_range(0, 2) == 0), kh, kl, 1'($urandom_range(0, 1)));
            end
         endcase
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      run_phase(8'd31, 8'd4, MIX_CLUSTER, 44, 1'b1);
      run_phase(8'd53, 8'd0, MIX_RANDOM, 40, 1'b1);
      run_phase(8'hc0, 8'hfc, MIX_RANDOM, 6, 1'b1);
      run_phase(8'd1, 8'd4, MIX_RANDOM, 24, 1'b0);
      run_phase(8'd32, 8'd4, MIX_RANDOM, 40, 1'b1);
      run_phase(8'd33, 8'd0, MIX_RANDOM, 30, 1'b0);
      run_phase(8'hbf, 8'd7, MIX_RANDOM, 50, 1'b1);
      run_phase(8'd20, 8'd2, MIX_HAMMER, 290, 1'b0);
      drain();
      quiet <= 1'b1;
      run_phase(8'd31, 8'd4, MIX_RANDOM, 40, 1'b0);
      drain();
      $display("sent %0d requests over nine register settings, checked %0d responses",
               sent, tally.checked);
      $display("covered probe chains past the limit, wraparound and count saturation");
      if (tally.errors == 0 && tally.pending.size() == 0)
         $display("kmer_count_hash_table verification clean");
      else
         $display("kmer_count_hash_table verification failed");
      $finish;
   end
endmodule
